// File: hdl/mrfd_pkg.sv
`timescale 1ns / 1ps

package mrfd_pkg;

    localparam int unsigned FRAME_LEN   = 16;
    localparam int unsigned POS_W       = $clog2(FRAME_LEN);
    localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
    localparam int unsigned BODY_FIRST  = 7;
    localparam int unsigned BODY_LEN    = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0] FRAME_HEAD   = 8'hAA;
    localparam logic [7:0] FRAME_TAIL   = 8'h55;
    localparam logic [7:0] OBJ_SPEED    = 8'h6C;
    localparam logic [7:0] OBJ_POSITION = 8'h64;
    localparam logic [7:0] SIDE_LEFT    = 8'h01;
    localparam logic [7:0] SIDE_RIGHT   = 8'h02;
    localparam logic [7:0] LEFT_ID_RST  = 8'h01;
    localparam logic [7:0] RIGHT_ID_RST = 8'h02;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_MODE = 2'd0,
        CFG_LEFT_ID     = 2'd1,
        CFG_RIGHT_ID    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_LEFT_MOTOR  = 3'd0,
        KIND_RIGHT_MOTOR = 3'd1,
        KIND_WHEEL_SPEED = 3'd2,
        KIND_LEFT_POS    = 3'd3,
        KIND_RIGHT_POS   = 3'd4
    } t_kind;

    // frame bytes 7..14; body[k] holds frame byte BODY_FIRST + k
    typedef struct packed {
        logic [BODY_LEN-1:0][7:0] body;
    } t_frame;

endpackage

// File: hdl/mrfd_rx_if.sv
`timescale 1ns / 1ps

interface mrfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_start;

    modport source(output valid, output rx_byte, output burst_start, input ready);
    modport sink(input valid, input rx_byte, input burst_start, output ready);
endinterface

// File: hdl/mrfd_res_if.sv
`timescale 1ns / 1ps

interface mrfd_res_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  frame_kind;
    logic        [15:0] motor_position_code;
    logic        [11:0] motor_velocity_code;
    logic        [11:0] motor_torque_code;
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
    logic signed [31:0] wheel_position_count;

    modport source(
        output valid, output frame_kind, output motor_position_code,
        output motor_velocity_code, output motor_torque_code,
        output left_wheel_speed, output right_wheel_speed,
        output wheel_position_count, input ready
    );
    modport sink(
        input valid, input frame_kind, input motor_position_code,
        input motor_velocity_code, input motor_torque_code,
        input left_wheel_speed, input right_wheel_speed,
        input wheel_position_count, output ready
    );
endinterface

// File: hdl/mrfd_front.sv
`timescale 1ns / 1ps

module mrfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrfd_rx_if.sink           i_rx,
    input  logic              i_q_full,
    output logic              o_push,
    output mrfd_pkg::t_frame  o_frame
);

    logic [mrfd_pkg::POS_W-1:0] r_pos;
    logic [mrfd_pkg::POS_W-1:0] n_pos;
    logic                       r_burst_ok;
    logic                       n_burst_ok;
    logic [7:0]                 r_bytes [mrfd_pkg::STORE_DEPTH];

    logic                       w_acc;
    logic [mrfd_pkg::POS_W-1:0] w_pos_eff;
    logic                       w_ok_eff;

    assign i_rx.ready = !i_q_full;
    assign w_acc      = i_rx.valid && i_rx.ready;

    always_comb begin
        if (i_rx.burst_start) begin
            w_pos_eff = '0;
            w_ok_eff  = (i_rx.rx_byte == mrfd_pkg::FRAME_HEAD);
        end else begin
            w_pos_eff = r_pos;
            w_ok_eff  = r_burst_ok;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_burst_ok = r_burst_ok;
        o_push     = 1'b0;
        if (w_acc) begin
            n_burst_ok = w_ok_eff;
            if (w_ok_eff) begin
                if (w_pos_eff == mrfd_pkg::FRAME_LAST) begin
                    n_pos  = '0;
                    o_push = (r_bytes[0] == mrfd_pkg::FRAME_HEAD) &&
                             (i_rx.rx_byte == mrfd_pkg::FRAME_TAIL);
                end else begin
                    n_pos = w_pos_eff + 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < mrfd_pkg::BODY_LEN; k++) begin
            o_frame.body[k] = r_bytes[mrfd_pkg::BODY_FIRST + k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_burst_ok <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_burst_ok <= n_burst_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_ok_eff && (w_pos_eff != mrfd_pkg::FRAME_LAST)) begin
            r_bytes[w_pos_eff] <= i_rx.rx_byte;
        end
    end

    a_push_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_pos == mrfd_pkg::FRAME_LAST) && r_burst_ok && !i_rx.burst_start)
        else $error("frame pushed before its last byte");

endmodule

// File: hdl/mrfd_queue.sv
`timescale 1ns / 1ps

module mrfd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mrfd_pkg::t_frame  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output mrfd_pkg::t_frame  o_data
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mrfd_pkg::t_frame  r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr;
    logic [IDX_W-1:0]  n_wr;
    logic [IDX_W-1:0]  r_rd;
    logic [IDX_W-1:0]  n_rd;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// File: hdl/mrfd_back.sv
`timescale 1ns / 1ps

module mrfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mrfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mrfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_q_valid,
    input  mrfd_pkg::t_frame                    i_q_data,
    output logic                                o_pop,
    mrfd_res_if.source                          o_res
);

    logic        r_mode;
    logic [7:0]  r_left_id;
    logic [7:0]  r_right_id;

    logic               r_valid;
    logic        [2:0]  r_kind;
    logic        [15:0] r_mpos;
    logic        [11:0] r_mvel;
    logic        [11:0] r_mtq;
    logic signed [15:0] r_lws;
    logic signed [15:0] r_rws;
    logic signed [31:0] r_wpc;

    logic               w_hit;
    mrfd_pkg::t_kind    w_kind;
    logic        [15:0] w_mpos;
    logic        [11:0] w_mvel;
    logic        [11:0] w_mtq;
    logic signed [15:0] w_lws;
    logic signed [15:0] w_rws;
    logic signed [31:0] w_wpc;
    logic               w_load;

    logic [7:0] f7, f8, f9, f10, f11, f12, f13, f14;

    assign f7  = i_q_data.body[0];
    assign f8  = i_q_data.body[1];
    assign f9  = i_q_data.body[2];
    assign f10 = i_q_data.body[3];
    assign f11 = i_q_data.body[4];
    assign f12 = i_q_data.body[5];
    assign f13 = i_q_data.body[6];
    assign f14 = i_q_data.body[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_left_id  <= mrfd_pkg::LEFT_ID_RST;
            r_right_id <= mrfd_pkg::RIGHT_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrfd_pkg::CFG_DEVICE_MODE: r_mode     <= i_cfg_data[0];
                mrfd_pkg::CFG_LEFT_ID:     r_left_id  <= i_cfg_data;
                mrfd_pkg::CFG_RIGHT_ID:    r_right_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_hit  = 1'b0;
        w_kind = mrfd_pkg::KIND_LEFT_MOTOR;
        w_mpos = '0;
        w_mvel = '0;
        w_mtq  = '0;
        w_lws  = '0;
        w_rws  = '0;
        w_wpc  = '0;
        if (!r_mode) begin
            if (f7 == r_left_id) begin
                w_hit  = 1'b1;
                w_kind = mrfd_pkg::KIND_LEFT_MOTOR;
            end else if (f7 == r_right_id) begin
                w_hit  = 1'b1;
                w_kind = mrfd_pkg::KIND_RIGHT_MOTOR;
            end
            if (w_hit) begin
                w_mpos = {f8, f9};
                w_mvel = {f10, f11[7:4]};
                w_mtq  = {f11[3:0], f12};
            end
        end else if (f8 == mrfd_pkg::OBJ_SPEED) begin
            w_hit  = 1'b1;
            w_kind = mrfd_pkg::KIND_WHEEL_SPEED;
            w_lws  = {f12, f11};
            w_rws  = {f14, f13};
        end else if (f8 == mrfd_pkg::OBJ_POSITION) begin
            if (f10 == mrfd_pkg::SIDE_LEFT) begin
                w_hit  = 1'b1;
                w_kind = mrfd_pkg::KIND_LEFT_POS;
            end else if (f10 == mrfd_pkg::SIDE_RIGHT) begin
                w_hit  = 1'b1;
                w_kind = mrfd_pkg::KIND_RIGHT_POS;
            end
            if (w_hit) begin
                w_wpc = {f14, f13, f12, f11};
            end
        end
    end

    // frames that decode to nothing are popped and dropped
    assign w_load = !r_valid || o_res.ready;
    assign o_pop  = i_q_valid && w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= w_kind;
            r_mpos <= w_mpos;
            r_mvel <= w_mvel;
            r_mtq  <= w_mtq;
            r_lws  <= w_lws;
            r_rws  <= w_rws;
            r_wpc  <= w_wpc;
        end
    end

    assign o_res.valid                = r_valid;
    assign o_res.frame_kind           = r_kind;
    assign o_res.motor_position_code  = r_mpos;
    assign o_res.motor_velocity_code  = r_mvel;
    assign o_res.motor_torque_code    = r_mtq;
    assign o_res.left_wheel_speed     = r_lws;
    assign o_res.right_wheel_speed    = r_rws;
    assign o_res.wheel_position_count = r_wpc;

    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(o_pop))
        else $error("result appeared without a queued frame");

endmodule

// File: hdl/motor_reply_frame_decoder.sv
`timescale 1ns / 1ps

// Decodes 16-byte reply frames from a serial byte stream. One byte is taken
// per clock; i_rx.ready drops only while the frame queue between the byte
// collector and the decoder holds QUEUE_DEPTH frames. A good frame's result
// passes the queue, then the output register. Bursts not starting with 0xAA
// are ignored, frames failing the head/tail check or with unknown IDs,
// objects or sides produce nothing, and partial frames at the end of a burst
// are discarded. The user must write configuration through i_cfg_* only
// while the block is idle; the block itself does not enforce this.

module motor_reply_frame_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mrfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mrfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mrfd_rx_if.sink                          i_rx,
    mrfd_res_if.source                       o_res
);

    logic             w_push;
    logic             w_pop;
    logic             w_q_valid;
    logic             w_q_full;
    mrfd_pkg::t_frame w_push_frame;
    mrfd_pkg::t_frame w_head_frame;

    mrfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_frame  (w_push_frame)
    );

    mrfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_frame),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_head_frame)
    );

    mrfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_head_frame),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [mrfd_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] rx_data;
        logic       opens_burst;
    } t_serial_byte;

    typedef struct packed {
        mrfd_pkg::t_kind    kind;
        logic        [15:0] position_code;
        logic        [11:0] velocity_code;
        logic        [11:0] torque_code;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic signed [31:0] position_count;
    } t_reply;

    typedef enum int {
        FL_LEFT_MOTOR, FL_RIGHT_MOTOR, FL_WHEEL_SPEED, FL_LEFT_POS, FL_RIGHT_POS,
        FL_BAD_HEAD, FL_BAD_TAIL, FL_BAD_ID, FL_BAD_OBJECT, FL_BAD_SIDE
    } t_reply_flavor;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [mrfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [mrfd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    mrfd_rx_if  rx_ch();
    mrfd_res_if res_ch();

    motor_reply_frame_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    t_serial_byte pending_bytes[$];
    t_reply       expected_replies[$];

    // decoder state as seen from the byte stream
    logic [7:0] dec_frame [mrfd_pkg::FRAME_LEN];
    logic [3:0] dec_pos = '0;
    logic       dec_in_burst = 1'b0;
    logic       dec_mode = 1'b0;
    logic [7:0] dec_left_id = mrfd_pkg::LEFT_ID_RST;
    logic [7:0] dec_right_id = mrfd_pkg::RIGHT_ID_RST;

    logic [7:0] reply_bytes [mrfd_pkg::FRAME_LEN];

    int  error_count = 0;
    int  phase_bytes = 0;
    bit  rx_fire = 1'b0;
    bit  rx_gaps_on = 1'b1;
    bit  res_stalls_on = 1'b1;
    int  gap_left = 0;
    int  burst_left = 4;
    int  holds_requested = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    int  pattern_age = 0;
    logic [15:0] stall_pattern = 16'hB5A3;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic decode_byte(input logic [7:0] b, input logic opens);
        t_reply r;
        bit     hit;
        if (opens) begin
            dec_pos = '0;
            dec_in_burst = (b == mrfd_pkg::FRAME_HEAD);
        end
        if (dec_in_burst) begin
            dec_frame[dec_pos] = b;
            if (dec_pos == mrfd_pkg::FRAME_LAST) begin
                dec_pos = '0;
                r = '0;
                hit = 1'b0;
                if (dec_frame[0] == mrfd_pkg::FRAME_HEAD &&
                    dec_frame[15] == mrfd_pkg::FRAME_TAIL) begin
                    if (!dec_mode) begin
                        if (dec_frame[7] == dec_left_id) begin
                            hit = 1'b1;
                            r.kind = mrfd_pkg::KIND_LEFT_MOTOR;
                        end else if (dec_frame[7] == dec_right_id) begin
                            hit = 1'b1;
                            r.kind = mrfd_pkg::KIND_RIGHT_MOTOR;
                        end
                        if (hit) begin
                            r.position_code = {dec_frame[8], dec_frame[9]};
                            r.velocity_code = {dec_frame[10], dec_frame[11][7:4]};
                            r.torque_code = {dec_frame[11][3:0], dec_frame[12]};
                        end
                    end else if (dec_frame[8] == mrfd_pkg::OBJ_SPEED) begin
                        hit = 1'b1;
                        r.kind = mrfd_pkg::KIND_WHEEL_SPEED;
                        r.left_speed = {dec_frame[12], dec_frame[11]};
                        r.right_speed = {dec_frame[14], dec_frame[13]};
                    end else if (dec_frame[8] == mrfd_pkg::OBJ_POSITION &&
                                 (dec_frame[10] == mrfd_pkg::SIDE_LEFT ||
                                  dec_frame[10] == mrfd_pkg::SIDE_RIGHT)) begin
                        hit = 1'b1;
                        r.kind = (dec_frame[10] == mrfd_pkg::SIDE_LEFT) ?
                                 mrfd_pkg::KIND_LEFT_POS : mrfd_pkg::KIND_RIGHT_POS;
                        r.position_count = {dec_frame[14], dec_frame[13],
                                            dec_frame[12], dec_frame[11]};
                    end
                end
                if (hit) begin
                    expected_replies.push_back(r);
                end
            end else begin
                dec_pos = dec_pos + 4'd1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : rx_monitor
        rx_fire = i_rst_n && rx_ch.valid && rx_ch.ready;
        if (rx_fire) begin
            decode_byte(rx_ch.rx_byte, rx_ch.burst_start);
            void'(pending_bytes.pop_front());
        end
    end

    always @(posedge i_clk) begin : res_monitor
        t_reply want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_replies.size() == 0) begin
                error_count++;
                $display("%0t: frame_kind expected none actual %h", $time, res_ch.frame_kind);
            end else begin
                want = expected_replies.pop_front();
                check_field("frame_kind", 32'(want.kind), 32'(res_ch.frame_kind));
                check_field("motor_position_code", 32'(want.position_code),
                            32'(res_ch.motor_position_code));
                check_field("motor_velocity_code", 32'(want.velocity_code),
                            32'(res_ch.motor_velocity_code));
                check_field("motor_torque_code", 32'(want.torque_code),
                            32'(res_ch.motor_torque_code));
                check_field("left_wheel_speed", 32'(want.left_speed),
                            32'(res_ch.left_wheel_speed));
                check_field("right_wheel_speed", 32'(want.right_speed),
                            32'(res_ch.right_wheel_speed));
                check_field("wheel_position_count", 32'(want.position_count),
                            32'(res_ch.wheel_position_count));
            end
        end
    end

    always @(negedge i_clk) begin : rx_driver
        bit offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (rx_ch.valid && !rx_fire) begin
                offer = 1'b1;
            end else if (rx_gaps_on && gap_left > 0) begin
                gap_left--;
            end else if (pending_bytes.size() > 0) begin
                offer = 1'b1;
                if (rx_gaps_on) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
        rx_ch.valid <= offer;
        if (offer) begin
            rx_ch.rx_byte <= pending_bytes[0].rx_data;
            rx_ch.burst_start <= pending_bytes[0].opens_burst;
        end
    end

    always @(negedge i_clk) begin : res_acceptor
        logic take;
        if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
        end else if (res_stalls_on) begin
            take = stall_pattern[0];
        end else begin
            take = 1'b1;
        end
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age++;
        if (pattern_age == 48) begin
            pattern_age = 0;
            stall_pattern = 16'($urandom) | 16'h0001;
        end
        res_ch.ready <= take;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        do begin
            v = pick_byte();
        end while (v == a || v == b);
        return v;
    endfunction

    function automatic t_reply_flavor pick_good(input logic mode);
        if (!mode) begin
            return $urandom_range(0, 1) ? FL_RIGHT_MOTOR : FL_LEFT_MOTOR;
        end
        case ($urandom_range(0, 2))
            0: return FL_WHEEL_SPEED;
            1: return FL_LEFT_POS;
            default: return FL_RIGHT_POS;
        endcase
    endfunction

    function automatic t_reply_flavor pick_flavor(input logic mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 72) return pick_good(mode);
        if (r < 78) return FL_BAD_HEAD;
        if (r < 84) return FL_BAD_TAIL;
        if (!mode || r < 88) return FL_BAD_ID;
        if (r < 94) return FL_BAD_OBJECT;
        return FL_BAD_SIDE;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic opens);
        t_serial_byte s;
        s.rx_data = b;
        s.opens_burst = opens;
        pending_bytes.push_back(s);
        phase_bytes++;
    endtask

    task automatic build_reply(input t_reply_flavor flavor);
        int i;
        for (i = 0; i < mrfd_pkg::FRAME_LEN; i++) begin
            reply_bytes[i] = pick_byte();
        end
        reply_bytes[0] = mrfd_pkg::FRAME_HEAD;
        reply_bytes[15] = mrfd_pkg::FRAME_TAIL;
        case (flavor)
            FL_LEFT_MOTOR: reply_bytes[7] = dec_left_id;
            FL_RIGHT_MOTOR: reply_bytes[7] = dec_right_id;
            FL_WHEEL_SPEED: reply_bytes[8] = mrfd_pkg::OBJ_SPEED;
            FL_LEFT_POS: begin
                reply_bytes[8] = mrfd_pkg::OBJ_POSITION;
                reply_bytes[10] = mrfd_pkg::SIDE_LEFT;
            end
            FL_RIGHT_POS: begin
                reply_bytes[8] = mrfd_pkg::OBJ_POSITION;
                reply_bytes[10] = mrfd_pkg::SIDE_RIGHT;
            end
            FL_BAD_HEAD: reply_bytes[0] =
                byte_other_than(mrfd_pkg::FRAME_HEAD, mrfd_pkg::FRAME_HEAD);
            FL_BAD_TAIL: reply_bytes[15] =
                byte_other_than(mrfd_pkg::FRAME_TAIL, mrfd_pkg::FRAME_TAIL);
            FL_BAD_ID: reply_bytes[7] = byte_other_than(dec_left_id, dec_right_id);
            FL_BAD_OBJECT: reply_bytes[8] =
                byte_other_than(mrfd_pkg::OBJ_SPEED, mrfd_pkg::OBJ_POSITION);
            FL_BAD_SIDE: begin
                reply_bytes[8] = mrfd_pkg::OBJ_POSITION;
                reply_bytes[10] = byte_other_than(mrfd_pkg::SIDE_LEFT, mrfd_pkg::SIDE_RIGHT);
            end
            default: ;
        endcase
    endtask

    task automatic queue_reply(input bit opens, input int unsigned len);
        int i;
        for (i = 0; i < len; i++) begin
            push_byte(reply_bytes[i], opens && i == 0);
        end
    endtask

    task automatic queue_burst();
        int n;
        int k;
        if ($urandom_range(0, 9) == 0) begin
            // rejected burst: everything up to the next burst start is dropped
            push_byte(byte_other_than(mrfd_pkg::FRAME_HEAD, mrfd_pkg::FRAME_HEAD), 1'b1);
            repeat ($urandom_range(0, 20)) push_byte(pick_byte(), 1'b0);
        end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                build_reply(pick_flavor(dec_mode));
                queue_reply(k == 0, mrfd_pkg::FRAME_LEN);
            end
            if ($urandom_range(0, 3) == 0) begin
                build_reply(pick_good(dec_mode));
                queue_reply(1'b0, $urandom_range(1, mrfd_pkg::FRAME_LEN - 1));
            end
        end
    endtask

    task automatic queue_random(input int n_bytes);
        phase_bytes = 0;
        while (phase_bytes < n_bytes) begin
            queue_burst();
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mrfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mrfd_pkg::CFG_DEVICE_MODE: dec_mode = data[0];
            mrfd_pkg::CFG_LEFT_ID: dec_left_id = data;
            mrfd_pkg::CFG_RIGHT_ID: dec_right_id = data;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic mode, input logic [7:0] left_id,
                             input logic [7:0] right_id, input int n_bytes,
                             input bit gaps, input bit stalls);
        wait_idle();
        write_reg(mrfd_pkg::CFG_DEVICE_MODE, {7'($urandom), mode});
        write_reg(mrfd_pkg::CFG_LEFT_ID, left_id);
        write_reg(mrfd_pkg::CFG_RIGHT_ID, right_id);
        rx_gaps_on = gaps;
        res_stalls_on = stalls;
        queue_random(n_bytes);
    endtask

    initial begin : stimulus
        logic [7:0] same_id;
        int k;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        rx_ch.burst_start = 1'b0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bytes before any burst start are ignored
        push_byte(mrfd_pkg::FRAME_HEAD, 1'b0);
        push_byte(mrfd_pkg::FRAME_TAIL, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        repeat (4) push_byte(8'hFF, 1'b0);
        build_reply(FL_LEFT_MOTOR);
        for (k = 8; k < 15; k++) reply_bytes[k] = 8'hFF;
        queue_reply(1'b1, mrfd_pkg::FRAME_LEN);
        build_reply(FL_RIGHT_MOTOR);
        for (k = 8; k < 15; k++) reply_bytes[k] = 8'h00;
        queue_reply(1'b0, mrfd_pkg::FRAME_LEN);
        build_reply(FL_BAD_TAIL);
        queue_reply(1'b0, mrfd_pkg::FRAME_LEN);
        build_reply(FL_LEFT_MOTOR);
        queue_reply(1'b0, 5);
        build_reply(FL_BAD_ID);
        queue_reply(1'b1, mrfd_pkg::FRAME_LEN);
        queue_random(80);

        run_phase(1'b0, 8'h00, 8'hFF, 120, 1'b0, 1'b0);
        run_phase(1'b1, pick_byte(), pick_byte(), 150, 1'b1, 1'b1);
        same_id = pick_byte();
        run_phase(1'b0, same_id, same_id, 100, 1'b1, 1'b0);

        run_phase(1'b1, pick_byte(), pick_byte(), 0, 1'b0, 1'b1);
        holds_requested++;
        for (k = 0; k < 10; k++) begin
            build_reply(pick_good(1'b1));
            queue_reply(k == 0, mrfd_pkg::FRAME_LEN);
        end
        queue_random(60);

        wait_idle();
        write_reg(CFG_NO_REG, pick_byte());
        run_phase(1'b0, 8'hFF, 8'h00, 120, 1'b1, 1'b1);
        run_phase(1'b1, pick_byte(), pick_byte(), 120, 1'b1, 1'b1);

        wait_idle();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
